### rtl/sfps_pkg.sv
// ----------------------------------------------------------------------------
// sfps_pkg
// Types, constants and the preamble table shared by the preamble strip block.
// ----------------------------------------------------------------------------
package sfps_pkg;

    // Number of preamble bytes, and so the number of hold cells.
    localparam int HOLD_DEPTH = 23;

    localparam logic [15:0] MIN_LEN   = 16'd42;
    localparam logic [4:0]  STAMP_LEN = 5'd16;
    localparam logic [4:0]  PRE_LEN   = 5'd23;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef struct packed {
        logic [7:0]  text_byte;
        logic        first_flag;
        logic        last_flag;
        logic [15:0] text_length;
    } sfps_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
        logic       preamble_removed;
    } sfps_out_t;

    // Control that every hold cell sees in the same cycle.
    typedef struct packed {
        logic       load_en;
        logic [4:0] load_pos;
        logic       shift_en;
    } sfps_cell_ctrl_t;

    // What the parser decides for one accepted beat.
    typedef struct packed {
        logic       hold_en;
        logic [4:0] hold_pos;
        logic [4:0] rep_cnt;
        logic       tail_en;
        sfps_out_t  tail;
    } sfps_dec_t;

    // Lower-case preamble text, one character per position.
    function automatic logic [7:0] preamble_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "m";
            5'd1:    c = "e";
            5'd2:    c = "s";
            5'd3:    c = "s";
            5'd4:    c = "a";
            5'd5:    c = "g";
            5'd6:    c = "e";
            5'd7:    c = " ";
            5'd8:    c = "f";
            5'd9:    c = "o";
            5'd10:   c = "r";
            5'd11:   c = "w";
            5'd12:   c = "a";
            5'd13:   c = "r";
            5'd14:   c = "d";
            5'd15:   c = "e";
            5'd16:   c = "d";
            5'd17:   c = " ";
            5'd18:   c = "f";
            5'd19:   c = "r";
            5'd20:   c = "o";
            5'd21:   c = "m";
            5'd22:   c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c | 8'h20;
        end
        return r;
    endfunction

endpackage

### rtl/sfps_cell.sv
// ----------------------------------------------------------------------------
// sfps_cell
// One hold cell: stores a preamble byte and hands it to its lower neighbor
// during a replay.
// ----------------------------------------------------------------------------
module sfps_cell
    import sfps_pkg::*;
(
    input  logic            aclk,
    input  sfps_cell_ctrl_t ctrl,
    input  logic [4:0]      cell_idx,
    input  logic [7:0]      load_byte,
    input  logic [7:0]      next_byte,
    output logic [7:0]      cell_byte
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_en) begin
            data_next = next_byte;
        end else if (ctrl.load_en && ctrl.load_pos == cell_idx) begin
            data_next = load_byte;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign cell_byte = data_reg;

endmodule

### rtl/sfps_parse.sv
// ----------------------------------------------------------------------------
// sfps_parse
// Message state and per-beat decision: which bytes pass, are held, replayed
// or dropped.
// ----------------------------------------------------------------------------
module sfps_parse
    import sfps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  sfps_in_t  in_beat,
    output sfps_dec_t dec
);

    localparam logic [2:0] PH_SPACE = 3'd0;
    localparam logic [2:0] PH_TIME  = 3'd1;
    localparam logic [2:0] PH_MATCH = 3'd2;
    localparam logic [2:0] PH_COLON = 3'd3;
    localparam logic [2:0] PH_PASS  = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [4:0]  match_pos_reg, match_pos_next;
    logic        removed_reg, removed_next;

    logic [15:0] rem;
    logic [2:0]  ph;
    logic [4:0]  mp;
    logic        rf;
    logic        emit;
    logic [4:0]  mp_inc;
    logic [4:0]  pos;
    logic [4:0]  pos_inc;
    logic [7:0]  b;
    logic        last;

    always_comb begin
        b    = in_beat.text_byte;
        last = in_beat.last_flag;
        rem  = in_beat.first_flag ? in_beat.text_length : remaining_reg;
        ph   = in_beat.first_flag ? PH_SPACE : phase_reg;
        mp   = in_beat.first_flag ? 5'd0 : match_pos_reg;
        rf   = in_beat.first_flag ? 1'b0 : removed_reg;

        phase_next     = ph;
        match_pos_next = mp;
        removed_next   = rf;
        remaining_next = (rem != 16'd0) ? rem - 16'd1 : 16'd0;
        emit           = 1'b1;
        mp_inc         = mp + 5'd1;
        pos            = (mp >= PRE_LEN) ? 5'd0 : mp;
        pos_inc        = pos + 5'd1;

        dec          = '0;
        dec.hold_pos = pos;

        unique case (ph)
            PH_SPACE: begin
                if (rem != 16'd0 && b == CHAR_SPACE) begin
                    phase_next = PH_SPACE;
                end else if (rem < MIN_LEN) begin
                    phase_next = PH_PASS;
                end else begin
                    match_pos_next = 5'd1;
                    phase_next     = PH_TIME;
                end
            end
            PH_TIME: begin
                if (mp_inc >= STAMP_LEN) begin
                    match_pos_next = 5'd0;
                    phase_next     = PH_MATCH;
                end else begin
                    match_pos_next = mp_inc;
                end
            end
            PH_MATCH: begin
                if (to_lower(b) == preamble_char(pos)) begin
                    if (pos_inc >= PRE_LEN) begin
                        removed_next   = 1'b1;
                        match_pos_next = 5'd0;
                        phase_next     = PH_COLON;
                        emit           = 1'b0;
                    end else if (last) begin
                        // The held bytes go out again and the current byte
                        // closes the message.
                        dec.rep_cnt = pos;
                    end else begin
                        match_pos_next = pos_inc;
                        dec.hold_en    = 1'b1;
                        emit           = 1'b0;
                    end
                end else begin
                    dec.rep_cnt    = pos;
                    match_pos_next = 5'd0;
                    phase_next     = PH_PASS;
                end
            end
            PH_COLON: begin
                if (b == CHAR_COLON) begin
                    emit       = 1'b0;
                    phase_next = PH_PASS;
                end else if (b == CHAR_SPACE) begin
                    phase_next = PH_PASS;
                end
            end
            default: begin
                phase_next = ph;
            end
        endcase

        dec.tail_en                = emit || last;
        dec.tail.out_byte          = emit ? b : 8'h00;
        dec.tail.byte_valid        = emit;
        dec.tail.out_last          = last;
        dec.tail.preamble_removed  = removed_next;

        if (last) begin
            phase_next     = PH_SPACE;
            remaining_next = 16'd0;
            match_pos_next = 5'd0;
            removed_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SPACE;
            remaining_reg <= 16'd0;
            match_pos_reg <= 5'd0;
            removed_reg   <= 1'b0;
        end else if (in_fire) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            match_pos_reg <= match_pos_next;
            removed_reg   <= removed_next;
        end
    end

endmodule

### rtl/syslog_forward_preamble_strip_core.sv
// ----------------------------------------------------------------------------
// syslog_forward_preamble_strip_core
// Strips the forwarded-from preamble after the timestamp of syslog text.
//
//   Channel  Ports                      Direction  Beat
//   input    s_valid s_ready s_data     in         one text byte (sfps_in_t)
//   result   m_valid m_ready m_data     out        one result (sfps_out_t)
//
// An accepted beat's final result waits in the tail register and moves to
// the output register once that is free. A mismatch replays the held bytes
// from the hold cell row at one byte per cycle while the output is free, up
// to 22 bytes. Reset clears the message state and the output valid flag.
// A stalled m_ready holds the output register and, behind it, the input.
// ----------------------------------------------------------------------------
module syslog_forward_preamble_strip_core
    import sfps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sfps_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output sfps_out_t m_data
);

    sfps_dec_t       dec;
    sfps_cell_ctrl_t cell_ctrl;
    logic [7:0]      cell_bytes [HOLD_DEPTH];

    logic [4:0] rep_left_reg, rep_left_next;
    logic       tail_pend_reg, tail_pend_next;
    sfps_out_t  tail_reg, tail_next;
    logic       m_valid_reg, m_valid_next;
    sfps_out_t  m_data_reg, m_data_next;

    logic in_fire;
    logic out_free;
    logic do_rep;
    logic do_tail;

    assign s_ready  = (rep_left_reg == 5'd0) && !tail_pend_reg;
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign do_rep   = out_free && (rep_left_reg != 5'd0);
    assign do_tail  = out_free && (rep_left_reg == 5'd0) && tail_pend_reg;

    sfps_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_beat (s_data),
        .dec     (dec)
    );

    always_comb begin
        cell_ctrl.load_en  = in_fire && dec.hold_en;
        cell_ctrl.load_pos = dec.hold_pos;
        cell_ctrl.shift_en = do_rep;
    end

    // Held bytes sit in order from cell 0; a replay reads cell 0 and shifts
    // the row down by one.
    genvar gi;
    generate
        for (gi = 0; gi < HOLD_DEPTH; gi++) begin : g_cell
            if (gi == HOLD_DEPTH - 1) begin : g_end
                sfps_cell u_cell (
                    .aclk      (aclk),
                    .ctrl      (cell_ctrl),
                    .cell_idx  (5'(gi)),
                    .load_byte (s_data.text_byte),
                    .next_byte (8'h00),
                    .cell_byte (cell_bytes[gi])
                );
            end else begin : g_mid
                sfps_cell u_cell (
                    .aclk      (aclk),
                    .ctrl      (cell_ctrl),
                    .cell_idx  (5'(gi)),
                    .load_byte (s_data.text_byte),
                    .next_byte (cell_bytes[gi+1]),
                    .cell_byte (cell_bytes[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        rep_left_next  = rep_left_reg;
        tail_pend_next = tail_pend_reg;
        tail_next      = tail_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (in_fire) begin
            rep_left_next  = dec.rep_cnt;
            tail_pend_next = dec.tail_en;
            tail_next      = dec.tail;
        end else if (do_rep) begin
            rep_left_next = rep_left_reg - 5'd1;
        end else if (do_tail) begin
            tail_pend_next = 1'b0;
        end

        if (do_rep) begin
            // Replayed bytes belong to a message whose preamble was not removed.
            m_valid_next                 = 1'b1;
            m_data_next.out_byte         = cell_bytes[0];
            m_data_next.byte_valid       = 1'b1;
            m_data_next.out_last         = 1'b0;
            m_data_next.preamble_removed = 1'b0;
        end else if (do_tail) begin
            m_valid_next = 1'b1;
            m_data_next  = tail_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_left_reg  <= 5'd0;
            tail_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rep_left_reg  <= rep_left_next;
            tail_pend_reg <= tail_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tail_reg   <= tail_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### test/syslog_forward_preamble_strip_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// syslog_forward_preamble_strip_core_tb
// Drives forwarded syslog text into the preamble strip core one byte per beat
// and checks every output beat against a behavioral prediction of the strip.
// Short directed messages cover each corner of the parser, and a few short
// random messages follow. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module syslog_forward_preamble_strip_core_tb;
    import sfps_pkg::*;

    typedef enum logic [2:0] {
        STRIP_LEAD_SPACE,
        STRIP_STAMP,
        STRIP_MATCH,
        STRIP_COLON,
        STRIP_PASS
    } strip_phase_e;

    localparam logic [8*23-1:0] PREAMBLE_TEXT = "message forwarded from ";
    localparam int              RANDOM_MSGS   = 3;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sfps_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sfps_out_t m_data;

    int        errors = 0;
    bit        steady = 1'b0;
    sfps_out_t expected_q[$];
    logic [7:0] msg_buf[$];

    // Prediction state of the strip.
    strip_phase_e strip_phase = STRIP_LEAD_SPACE;
    logic [15:0]  bytes_left = '0;
    logic [4:0]   match_pos = '0;
    logic [7:0]   held_text[HOLD_DEPTH];
    logic         removed_seen = 1'b0;

    syslog_forward_preamble_strip_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 28);
    end

    function automatic logic [7:0] preamble_at(input int idx);
        return PREAMBLE_TEXT[8*(22-idx) +: 8];
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function void push_result(input logic [7:0] b, input logic valid, input logic last);
        sfps_out_t r;
        r.out_byte         = b;
        r.byte_valid       = valid;
        r.out_last         = last;
        r.preamble_removed = removed_seen;
        expected_q.push_back(r);
    endfunction

    // Works out the output beats caused by one accepted input beat.
    function void predict_strip(input sfps_in_t d);
        logic [15:0] left_now;
        logic [4:0]  pos;
        logic [7:0]  b;
        bit          pass_byte;
        int          n;
        b         = d.text_byte;
        pass_byte = 1'b1;
        n         = 0;
        if (d.first_flag) begin
            strip_phase  = STRIP_LEAD_SPACE;
            match_pos    = '0;
            removed_seen = 1'b0;
            bytes_left   = d.text_length;
        end
        left_now = bytes_left;
        if (bytes_left != 0) begin
            bytes_left = bytes_left - 16'd1;
        end

        case (strip_phase)
            STRIP_LEAD_SPACE: begin
                if (left_now != 0 && b == CHAR_SPACE) begin
                    // Leading space goes straight through.
                end else if (left_now < MIN_LEN) begin
                    strip_phase = STRIP_PASS;
                end else begin
                    match_pos   = 5'd1;
                    strip_phase = STRIP_STAMP;
                end
            end
            STRIP_STAMP: begin
                match_pos = match_pos + 5'd1;
                if (match_pos >= STAMP_LEN) begin
                    match_pos   = '0;
                    strip_phase = STRIP_MATCH;
                end
            end
            STRIP_MATCH: begin
                pos = match_pos;
                if (pos >= PRE_LEN) begin
                    pos = '0;
                end
                if (fold_case(b) == preamble_at(pos)) begin
                    held_text[pos] = b;
                    pos            = pos + 5'd1;
                    pass_byte      = 1'b0;
                    if (pos >= PRE_LEN) begin
                        removed_seen = 1'b1;
                        match_pos    = '0;
                        strip_phase  = STRIP_COLON;
                    end else if (d.last_flag) begin
                        for (int i = 0; i < pos; i++) begin
                            push_result(held_text[i], 1'b1, i + 1 == pos);
                            n++;
                        end
                    end else begin
                        match_pos = pos;
                    end
                end else begin
                    for (int i = 0; i < pos; i++) begin
                        push_result(held_text[i], 1'b1, 1'b0);
                        n++;
                    end
                    match_pos   = '0;
                    strip_phase = STRIP_PASS;
                end
            end
            STRIP_COLON: begin
                if (b == CHAR_COLON) begin
                    pass_byte   = 1'b0;
                    strip_phase = STRIP_PASS;
                end else if (b == CHAR_SPACE) begin
                    strip_phase = STRIP_PASS;
                end
            end
            default: begin
            end
        endcase

        if (pass_byte) begin
            push_result(b, 1'b1, d.last_flag);
        end else if (d.last_flag && n == 0) begin
            push_result(8'h00, 1'b0, 1'b1);
        end

        if (d.last_flag) begin
            strip_phase  = STRIP_LEAD_SPACE;
            bytes_left   = '0;
            match_pos    = '0;
            removed_seen = 1'b0;
        end
    endfunction

    // Output checker: every beat must match the oldest expected beat.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected output beat %h", $realtime, m_data);
                errors++;
            end else begin
                if (m_data.out_byte !== expected_q[0].out_byte) begin
                    $display("%0t: out_byte expected %h actual %h", $realtime,
                             expected_q[0].out_byte, m_data.out_byte);
                    errors++;
                end
                if (m_data.byte_valid !== expected_q[0].byte_valid) begin
                    $display("%0t: byte_valid expected %b actual %b", $realtime,
                             expected_q[0].byte_valid, m_data.byte_valid);
                    errors++;
                end
                if (m_data.out_last !== expected_q[0].out_last) begin
                    $display("%0t: out_last expected %b actual %b", $realtime,
                             expected_q[0].out_last, m_data.out_last);
                    errors++;
                end
                if (m_data.preamble_removed !== expected_q[0].preamble_removed) begin
                    $display("%0t: preamble_removed expected %b actual %b", $realtime,
                             expected_q[0].preamble_removed, m_data.preamble_removed);
                    errors++;
                end
                void'(expected_q.pop_front());
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input sfps_in_t d);
        while (!steady && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_strip(d);
        @(negedge aclk);
    endtask

    task automatic send_message(input logic [15:0] len, input bit with_first,
                                input bit with_last);
        sfps_in_t d;
        for (int i = 0; i < msg_buf.size(); i++) begin
            d.text_byte   = msg_buf[i];
            d.first_flag  = with_first && (i == 0);
            d.last_flag   = with_last && (i == msg_buf.size() - 1);
            d.text_length = (i == 0) ? len : 16'($urandom);
            send_byte(d);
        end
        s_valid <= 1'b0;
        msg_buf.delete();
        @(negedge aclk);
    endtask

    task automatic add_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            msg_buf.push_back(t[i]);
        end
    endtask

    task automatic add_stamp();
        repeat (16) msg_buf.push_back(8'($urandom));
    endtask

    // First n preamble characters, each letter in random case.
    task automatic add_preamble(input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = preamble_at(i);
            if (c != CHAR_SPACE && $urandom_range(0, 1)) begin
                c = c - 8'd32;
            end
            msg_buf.push_back(c);
        end
    endtask

    task automatic add_miss(input int pos);
        logic [7:0] c;
        do begin
            c = 8'($urandom);
        end while (fold_case(c) == preamble_at(pos));
        msg_buf.push_back(c);
    endtask

    task automatic add_random(input int n, input bit delims);
        logic [7:0] c;
        repeat (n) begin
            do begin
                c = 8'($urandom);
            end while (!delims && (c == CHAR_SPACE || c == CHAR_COLON));
            msg_buf.push_back(c);
        end
    endtask

    task automatic test_short_messages();
        add_text("  hi:x");
        send_message(16'd6, 1'b1, 1'b1);
        // The length runs out inside the leading spaces.
        add_text("  ab");
        send_message(16'd1, 1'b1, 1'b1);
        add_text("z");
        send_message(16'd0, 1'b1, 1'b1);
    endtask

    // Full preamble, then a byte that passes and a final colon that is dropped.
    task automatic test_full_strip();
        add_stamp();
        add_preamble(23);
        add_text("a:");
        send_message(16'd42, 1'b1, 1'b1);
    endtask

    // The longest replay, sent without idling on either side.
    task automatic test_mismatch_replay();
        steady = 1'b1;
        add_stamp();
        add_preamble(22);
        add_miss(22);
        send_message(16'd50, 1'b1, 1'b1);
        steady = 1'b0;
    endtask

    task automatic test_end_while_held();
        add_stamp();
        add_preamble(3);
        send_message(16'hFFFF, 1'b1, 1'b1);
    endtask

    task automatic test_stray_bytes();
        add_text("ab");
        send_message(16'h8000, 1'b0, 1'b1);
    endtask

    task automatic test_random_traffic();
        for (int k = 0; k < RANDOM_MSGS; k++) begin
            add_random($urandom_range(1, 3), 1'b1);
            send_message(16'($urandom), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_short_messages();
        test_full_strip();
        test_mismatch_replay();
        test_end_while_held();
        test_stray_bytes();
        test_random_traffic();
        while (expected_q.size() != 0) begin
            @(posedge aclk);
        end
        // Any stray extra beat would show up in this window.
        repeat (60) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
